// File: rtl/core/gblur_pkg.sv
// Shared types and constants for the Gaussian line blur.
package gblur_pkg;
   localparam int COLOR_W  = 8;
   localparam int WEIGHT_W = 16;
   localparam int TAP_REGS = 7;
   localparam int CSR_W    = 3;
   localparam int RAD_W    = 3;

   localparam logic [CSR_W-1:0] CSR_RADIUS = 3'd0;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   typedef logic [TAP_REGS-1:0][WEIGHT_W-1:0] tap_arr_type;
endpackage

// File: rtl/core/gblur_if.sv
// Channel interfaces: pixel request, blurred response, register write.
interface gblur_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;
   logic       line_end;
   modport source (output valid, in_red, in_green, in_blue, line_end, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, line_end, output ready);
endinterface

interface gblur_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       out_line_end;
   modport source (output valid, out_red, out_green, out_blue, out_line_end, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_line_end, output ready);
endinterface

interface gblur_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/gblur_cell.sv
// Window cell: holds one pixel and adds its weighted term to the passing sums.
module gblur_cell #(
   parameter int IDX   = 0,
   parameter int LW    = 13,
   parameter int ACC_W = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  gblur_pkg::pixel_type          pix_in,
   input  logic [LW-1:0]                 n_cnt,
   input  logic [LW-1:0]                 pos_lag,
   input  logic [gblur_pkg::RAD_W-1:0]   rad,
   input  gblur_pkg::tap_arr_type        taps,
   input  logic [3:0][ACC_W-1:0]         sum_in,
   output gblur_pkg::pixel_type          pix_ff,
   output logic [3:0][ACC_W-1:0]         sum_ff
);
   import gblur_pkg::*;

   logic signed [LW+1:0]  diff;
   logic [LW+1:0]         mag;
   logic                  use_tap;
   logic [WEIGHT_W-1:0]   w;
   logic [3:0][ACC_W-1:0] sum_in_next;

   always_comb begin
      diff    = $signed({2'b00, pos_lag}) - $signed((LW+2)'(IDX));
      mag     = diff[LW+1] ? (LW+2)'(-diff) : (LW+2)'(diff);
      use_tap = ((LW+1)'(IDX) < {1'b0, n_cnt}) && (mag <= (LW+2)'(rad));
      w       = use_tap ? taps[mag[RAD_W-1:0]] : '0;
      sum_in_next[0] = sum_in[0] + ACC_W'(w) * ACC_W'(pix_ff.red);
      sum_in_next[1] = sum_in[1] + ACC_W'(w) * ACC_W'(pix_ff.green);
      sum_in_next[2] = sum_in[2] + ACC_W'(w) * ACC_W'(pix_ff.blue);
      sum_in_next[3] = sum_in[3] + ACC_W'(w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else if (shift_en) begin
         pix_ff <= pix_in;
      end
      sum_ff <= sum_in_next;
   end
endmodule

// File: rtl/core/gblur_div.sv
// Restoring divider, one quotient bit per cycle for all three colors.
module gblur_div #(
   parameter int ACC_W = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [3:0][ACC_W-1:0] num,
   output logic [2:0][7:0]       quo_ff,
   output logic                  done_ff
);
   import gblur_pkg::*;

   localparam int DW = ACC_W + 8;

   logic [2:0][DW-1:0] rem_ff;
   logic [ACC_W-1:0]   den_ff;
   logic [2:0]         bit_ff;
   logic               busy_ff;
   logic [DW-1:0]      den_sh;

   assign den_sh = DW'(den_ff) << bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (bit_ff == 3'd0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (bit_ff == 3'd0)) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         for (int c = 0; c < 3; c++) begin
            rem_ff[c] <= DW'(num[c]);
         end
         den_ff <= num[3];
         bit_ff <= 3'd7;
      end else if (busy_ff) begin
         for (int c = 0; c < 3; c++) begin
            if (rem_ff[c] >= den_sh) begin
               rem_ff[c]         <= rem_ff[c] - den_sh;
               quo_ff[c][bit_ff] <= 1'b1;
            end else begin
               quo_ff[c][bit_ff] <= 1'b0;
            end
         end
         bit_ff <= bit_ff - 3'd1;
      end
   end
endmodule

// File: rtl/core/gaussian_line_blur.sv
// Top level of the Gaussian line blur: cell chain, sequencer, divider, registers.
//
//   channel  | dir | handshake   | payload
//   req_ch   | in  | valid/ready | in_red, in_green, in_blue, line_end
//   rsp_ch   | out | valid/ready | out_red, out_green, out_blue, out_line_end
//   csr_ch   | in  | valid/ready | index, data (always ready)
//
// One request at a time. Each result settles its sum through the cell chain, then
// passes through the divider and leaves through the output state.
// A request gives up to min(MAX_RADIUS,6)+1 results; a line end flushes them.
// Synchronous reset clears counters, sequencer, radius; taps reset to identity.
// A stalled response holds the sequencer in its output state.
module gaussian_line_blur #(
   parameter int MAX_RADIUS = 6,
   parameter int MAX_LINE   = 4096
) (
   input logic         clock,
   input logic         reset,
   gblur_req_if.sink   req_ch,
   gblur_rsp_if.source rsp_ch,
   gblur_csr_if.sink   csr_ch
);
   import gblur_pkg::*;

   localparam int WIN     = 2 * MAX_RADIUS + 1;
   localparam int RAD_LIM = (MAX_RADIUS < 6) ? MAX_RADIUS : 6;
   localparam int ACC_W   = 24 + $clog2(WIN);
   localparam int LW      = $clog2(MAX_LINE + 1);
   localparam int WC_W    = $clog2(WIN + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type              state_ff;
   logic [LW-1:0]          n_ff, e_ff;
   logic                   end_ff;
   logic [2:0]             cnt_ff;
   logic [WC_W-1:0]        wait_ff;
   logic [RAD_W-1:0]       radius_ff;
   tap_arr_type            tap_ff;
   logic                   rsp_valid_ff;
   logic [2:0][7:0]        out_ff;
   logic                   last_ff;

   logic [RAD_W-1:0]       r_eff;
   logic                   accept, shift_en, div_start, div_done;
   logic [LW-1:0]          n_in, e_next, pos_lag;
   logic                   end_in, more;
   logic [2:0]             cnt_next;
   pixel_type              pix_new;
   pixel_type              pix [WIN+1];
   logic [3:0][ACC_W-1:0]  sums [WIN+1];
   logic [2:0][7:0]        quo;

   assign r_eff = (radius_ff > RAD_W'(RAD_LIM)) ? RAD_W'(RAD_LIM) : radius_ff;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept   = req_ch.valid && req_ch.ready;
   assign shift_en = accept;
   assign pix_new  = '{red: req_ch.in_red, green: req_ch.in_green, blue: req_ch.in_blue};
   assign n_in     = n_ff + LW'(1);
   assign end_in   = req_ch.line_end || ({1'b0, n_in} >= (LW+1)'(MAX_LINE));
   assign pos_lag  = n_ff - LW'(1) - e_ff;
   assign div_start = (state_ff == ST_SUM) && (wait_ff == WC_W'(WIN));
   assign e_next   = e_ff + LW'(1);
   assign cnt_next = cnt_ff + 3'd1;
   assign more     = (e_next < n_ff) && (cnt_next < 3'(RAD_LIM + 1)) &&
                     (end_ff || ((LW+1)'(e_next) + (LW+1)'(r_eff) < (LW+1)'(n_ff)));

   assign pix[0]  = pix_new;
   assign sums[0] = '0;

   for (genvar i = 0; i < WIN; i++) begin : g_cell
      gblur_cell #(.IDX(i), .LW(LW), .ACC_W(ACC_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .pix_in   (pix[i]),
         .n_cnt    (n_ff),
         .pos_lag  (pos_lag),
         .rad      (r_eff),
         .taps     (tap_ff),
         .sum_in   (sums[i]),
         .pix_ff   (pix[i+1]),
         .sum_ff   (sums[i+1])
      );
   end

   gblur_div #(.ACC_W(ACC_W)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (sums[WIN]),
      .quo_ff  (quo),
      .done_ff (div_done)
   );

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         tap_ff    <= tap_arr_type'({{((TAP_REGS-1)*WEIGHT_W){1'b0}}, 16'hFFFF});
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_RADIUS: radius_ff <= csr_ch.data[RAD_W-1:0];
            default:    tap_ff[csr_ch.index - 3'd1] <= csr_ch.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         e_ff         <= '0;
         end_ff       <= 1'b0;
         cnt_ff       <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  end_ff  <= end_in;
                  cnt_ff  <= '0;
                  wait_ff <= '0;
                  if (end_in || ((LW+1)'(e_ff) + (LW+1)'(r_eff) < (LW+1)'(n_in))) begin
                     n_ff     <= n_in;
                     state_ff <= ST_SUM;
                  end else begin
                     n_ff <= n_in;
                  end
               end
            end
            ST_SUM: begin
               wait_ff <= wait_ff + WC_W'(1);
               if (div_start) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
                  cnt_ff       <= cnt_next;
                  wait_ff      <= '0;
                  if (more) begin
                     e_ff     <= e_next;
                     state_ff <= ST_SUM;
                  end else begin
                     state_ff <= ST_IDLE;
                     if (end_ff) begin
                        n_ff <= '0;
                        e_ff <= '0;
                     end else begin
                        e_ff <= e_next;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && div_done) begin
         out_ff  <= (sums[WIN][3] == '0) ? '0 : quo;
         last_ff <= end_ff && !more;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_red      = out_ff[0];
   assign rsp_ch.out_green    = out_ff[1];
   assign rsp_ch.out_blue     = out_ff[2];
   assign rsp_ch.out_line_end = last_ff;
endmodule

// File: test/gblur_tb_if.sv
// Testbench copies are not needed; interfaces come from the RTL. This file holds shared tb types.
package gblur_tb_pkg;
   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       line_end;
   } blur_result_type;
endpackage

// File: test/gaussian_line_blur_tb.sv
// Self-checking testbench for gaussian_line_blur: directed rows, random lines, predictor.
module gaussian_line_blur_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gblur_pkg::*;
   import gblur_tb_pkg::*;

   localparam int RAD_MAX   = 6;
   localparam int LINE_MAX  = 4096;
   localparam int WIN_DEPTH = 2 * RAD_MAX + 1;
   localparam int N_RANDOM  = 450;

   logic clock = 0;
   logic reset = 1;

   gblur_req_if req_ch();
   gblur_rsp_if rsp_ch();
   gblur_csr_if csr_ch();

   gaussian_line_blur i_dut (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   pixel_type   line_window[WIN_DEPTH];
   int          line_count;
   int          emit_count;
   logic [2:0]  blur_radius;
   tap_arr_type tap_weights;

   blur_result_type blurred_q[$];
   int error_count = 0;
   int result_count = 0;
   int request_count = 0;
   int line_ends = 0;
   bit sending_done = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, result_count);
      error_count++;
   endtask

   function automatic blur_result_type blur_position(input int x, input int n, input int r);
      blur_result_type res;
      longint unsigned acc_r, acc_g, acc_b, wsum, w;
      int k, idx;
      acc_r = 0; acc_g = 0; acc_b = 0; wsum = 0;
      for (int d = -r; d <= r; d++) begin
         k = x + d;
         idx = n - 1 - k;
         if (k >= 0 && k < n && idx >= 0 && idx < WIN_DEPTH) begin
            w = tap_weights[d < 0 ? -d : d];
            acc_r += w * line_window[idx].red;
            acc_g += w * line_window[idx].green;
            acc_b += w * line_window[idx].blue;
            wsum += w;
         end
      end
      res.red   = (wsum == 0) ? 8'd0 : 8'(acc_r / wsum);
      res.green = (wsum == 0) ? 8'd0 : 8'(acc_g / wsum);
      res.blue  = (wsum == 0) ? 8'd0 : 8'(acc_b / wsum);
      res.line_end = 1'b0;
      return res;
   endfunction

   task automatic predict_blur(input pixel_type px, input logic last);
      int r, n, e, cnt;
      bit at_end;
      r = (blur_radius > RAD_MAX) ? RAD_MAX : blur_radius;
      for (int i = WIN_DEPTH - 1; i > 0; i--) line_window[i] = line_window[i-1];
      line_window[0] = px;
      n = line_count + 1;
      at_end = last || n >= LINE_MAX;
      e = emit_count;
      cnt = 0;
      while (e < n && cnt < RAD_MAX + 1 && (at_end || e + r < n)) begin
         blurred_q.push_back(blur_position(e, n, r));
         e++;
         cnt++;
      end
      if (at_end) begin
         if (cnt > 0) blurred_q[$].line_end = 1'b1;
         line_count = 0;
         emit_count = 0;
         line_ends++;
      end else begin
         line_count = n;
         emit_count = e;
      end
   endtask

   task automatic write_csr(input int index, input logic [15:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= 3'(index);
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (index == CSR_RADIUS) blur_radius = value[2:0];
      else tap_weights[index-1] = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_type px, input logic last, input bit use_gap);
      int gap;
      gap = use_gap ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.in_red   <= px.red;
      req_ch.in_green <= px.green;
      req_ch.in_blue  <= px.blue;
      req_ch.line_end <= last;
      do @(posedge clock); while (!req_ch.ready);
      predict_blur(px, last);
      request_count++;
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic set_taps(input int r, input int mode);
      write_csr(CSR_RADIUS, 16'(r));
      for (int i = 0; i < TAP_REGS; i++) begin
         case (mode)
            0: write_csr(i + 1, 16'(16'hFFFF >> i));
            1: write_csr(i + 1, 16'hFFFF);
            2: write_csr(i + 1, 16'h0000);
            default: write_csr(i + 1, 16'($urandom_range(0, 65535)));
         endcase
      end
   endtask

   // receiver with random stall
   initial begin
      blur_result_type want;
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (blurred_q.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = blurred_q.pop_front();
            if (rsp_ch.out_red !== want.red)
               report_mismatch("red", rsp_ch.out_red, want.red);
            if (rsp_ch.out_green !== want.green)
               report_mismatch("green", rsp_ch.out_green, want.green);
            if (rsp_ch.out_blue !== want.blue)
               report_mismatch("blue", rsp_ch.out_blue, want.blue);
            if (rsp_ch.out_line_end !== want.line_end)
               report_mismatch("line_end", rsp_ch.out_line_end, want.line_end);
         end
         result_count++;
         @(negedge clock);
      end
   end

   // directed table: pixel, line_end
   typedef struct {
      logic [23:0] px;
      logic        last;
   } stim_row_type;

   stim_row_type directed_rows[] = '{
      '{24'hFFFFFF, 1'b1}, '{24'h000000, 1'b1}, '{24'hA55A0F, 1'b1},
      '{24'h102030, 1'b0}, '{24'hFF00FF, 1'b0}, '{24'h00FF00, 1'b0},
      '{24'h7F8081, 1'b0}, '{24'h010203, 1'b1}
   };

   initial begin
      pixel_type px;
      int line_len, r, mode;
      req_ch.valid = 0; req_ch.in_red = 0; req_ch.in_green = 0; req_ch.in_blue = 0;
      req_ch.line_end = 0;
      csr_ch.valid = 0; csr_ch.index = 0; csr_ch.data = 0;
      foreach (line_window[i]) line_window[i] = '0;
      line_count = 0; emit_count = 0; blur_radius = 0;
      tap_weights = '0;
      tap_weights[0] = 16'hFFFF;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: identity blur, result equals input
      for (int i = 0; i < 3; i++) begin
         send_pixel(directed_rows[i].px, directed_rows[i].last, 1'b0);
         if (blurred_q.size() != 0 && blurred_q[$].red !== directed_rows[i].px[23:16]) begin
            $display("identity row %0d predicted wrong", i);
            error_count++;
         end
      end
      end_burst();
      wait_drained();

      // radius extremes, zero weights, all-max weights, mid-line radius change
      for (int pass = 0; pass < 4; pass++) begin
         set_taps(pass == 3 ? 7 : (pass == 0 ? 6 : 1), pass == 3 ? 0 : pass);
         for (int i = 3; i < directed_rows.size(); i++)
            send_pixel(directed_rows[i].px, directed_rows[i].last, 1'b1);
         end_burst();
         wait_drained();
      end
      set_taps(6, 0);
      for (int i = 0; i < 4; i++)
         send_pixel(pixel_type'(24'(24'h3C3C3C * i)), 1'b0, 1'b0);
      end_burst();
      wait_drained();
      write_csr(CSR_RADIUS, 16'd1);
      for (int i = 0; i < 9; i++) send_pixel(pixel_type'(24'($urandom)), i == 8, 1'b0);
      end_burst();
      wait_drained();

      // random lines, new settings between phases
      while (request_count < N_RANDOM) begin
         if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 7);
            mode = $urandom_range(0, 5);
            end_burst();
            wait_drained();
            set_taps(r, mode);
         end
         line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
         for (int i = 0; i < line_len; i++) begin
            px = pixel_type'(24'($urandom));
            send_pixel(px, i == line_len - 1, $urandom_range(0, 2) != 0);
         end
      end
      end_burst();
      sending_done = 1;
   end

   initial begin
      wait (sending_done);
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("covered %0d requests, %0d lines, %0d checked results",
               request_count, line_ends, result_count);
      if (error_count == 0 && blurred_q.size() == 0)
         $display("gaussian_line_blur_tb OK");
      else
         $display("gaussian_line_blur_tb NOT OK");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout after %0d results", result_count);
      $display("gaussian_line_blur_tb NOT OK");
      $finish;
   end
endmodule
